FILE: src/mqttp_pkg.sv
// Shared types, codes and the property table of the MQTT 5 property parser.
// No dependencies; used by every module of the block.
package mqttp_pkg;

	localparam logic [2:0] KIND_BYTE    = 3'd0;
	localparam logic [2:0] KIND_TWO     = 3'd1;
	localparam logic [2:0] KIND_FOUR    = 3'd2;
	localparam logic [2:0] KIND_VARINT  = 3'd3;
	localparam logic [2:0] KIND_STRING  = 3'd4;
	localparam logic [2:0] KIND_PAIR    = 3'd5;
	localparam logic [2:0] KIND_BINARY  = 3'd6;
	localparam logic [2:0] KIND_UNKNOWN = 3'd7;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNKNOWN   = 3'd1;
	localparam logic [2:0] ST_TRUNC     = 3'd2;
	localparam logic [2:0] ST_TOO_LONG  = 3'd3;
	localparam logic [2:0] ST_MALFORMED = 3'd4;

	localparam logic [7:0] VB_CONT = 8'h80;
	localparam logic [7:0] VB_DATA = 8'h7F;

	typedef struct packed {
		logic        is_property;
		logic [6:0]  property_id;
		logic [2:0]  value_kind;
		logic [31:0] value;
		logic [15:0] second_length;
		logic        is_end;
		logic [2:0]  status;
		logic        last_result;
	} res_t;

	function automatic logic [2:0] kind_of(input logic [6:0] id);
		logic [2:0] k;
		begin
			case (id)
				7'h01, 7'h17, 7'h19, 7'h24, 7'h25, 7'h28, 7'h29, 7'h2A: k = KIND_BYTE;
				7'h13, 7'h21, 7'h22, 7'h23:                             k = KIND_TWO;
				7'h02, 7'h11, 7'h18, 7'h27:                             k = KIND_FOUR;
				7'h0B:                                                  k = KIND_VARINT;
				7'h03, 7'h08, 7'h12, 7'h15, 7'h1A, 7'h1C, 7'h1F:        k = KIND_STRING;
				7'h26:                                                  k = KIND_PAIR;
				7'h09, 7'h16:                                           k = KIND_BINARY;
				default:                                                k = KIND_UNKNOWN;
			endcase
			kind_of = k;
		end
	endfunction

endpackage

FILE: src/mqtt5_property_stream_parser_top.sv
// Top level of the MQTT 5 property stream parser.
// Depends on mqttp_pkg, mqttp_step and mqttp_out_fifo.
//
// Takes one property-area byte per beat and reports each completed property
// (identifier, value kind, big-endian value or string/binary lengths) plus an
// end-of-area status beat on the byte flagged last_byte. Payload bytes of
// strings and binary data are skipped; the first error is sticky until the
// end of the area. Timing: a byte is registered on acceptance and parsed from
// that register by a single step of combinational logic once the queue has
// room for two results; its results land in a four-entry queue and leave from
// its head. One byte per cycle is sustained; a byte yields zero, one or two
// result beats, and the parse stage waits only when the queue has fewer than
// two free slots, so throughput is one byte per cycle as long as results are
// drained at least as fast as they appear. max_string_length may be written
// at any time the block is idle; cfg_ready is always high.
module mqtt5_property_stream_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// input byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_property,
	output logic [6:0]  property_id,
	output logic [2:0]  value_kind,
	output logic [31:0] value,
	output logic [15:0] second_length,
	output logic        is_end,
	output logic [2:0]  status,
	output logic        last_result,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] max_string_length
);
	import mqttp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [15:0] max_len_q;
	logic        room2;
	logic        fire;
	res_t        r0;
	res_t        r1;
	logic [1:0]  n_res;
	logic [1:0]  push_n;
	res_t        head;
	logic        pop;

	// the register port never back-pressures
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= max_string_length;
		end
	end

	// input register: refills in the same cycle the held byte is parsed
	assign fire     = valid_s1 && room2;
	assign in_stall = valid_s1 && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	mqttp_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.max_len (max_len_q),
		.r0      (r0),
		.r1      (r1),
		.n_res   (n_res)
	);

	assign push_n = fire ? n_res : 2'd0;
	assign pop    = out_valid && !out_stall;

	mqttp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push0     (r0),
		.push1     (r1),
		.pop       (pop),
		.head      (head),
		.not_empty (out_valid),
		.room2     (room2)
	);

	assign is_property   = head.is_property;
	assign property_id   = head.property_id;
	assign value_kind    = head.value_kind;
	assign value         = head.value;
	assign second_length = head.second_length;
	assign is_end        = head.is_end;
	assign status        = head.status;
	assign last_result   = head.last_result;

endmodule

FILE: src/mqttp_step.sv
// Per-byte parse step: parser state registers and the next-state / result logic.
// Depends on mqttp_pkg. Produces up to two results per consumed byte.
module mqttp_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        byte_in,
	input  logic              last_in,
	input  logic [15:0]       max_len,
	output mqttp_pkg::res_t   r0,
	output mqttp_pkg::res_t   r1,
	output logic [1:0]        n_res
);
	import mqttp_pkg::*;

	localparam logic [2:0] PH_ID      = 3'd0;
	localparam logic [2:0] PH_FIXED   = 3'd1;
	localparam logic [2:0] PH_VARINT  = 3'd2;
	localparam logic [2:0] PH_LEN_HI  = 3'd3;
	localparam logic [2:0] PH_LEN_LO  = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;

	logic [2:0]  phase_q, phase_d;
	logic [6:0]  id_q, id_d;
	logic [31:0] acc_q, acc_d;
	logic [15:0] rem_q, rem_d;
	logic [1:0]  vcnt_q, vcnt_d;
	logic [15:0] flen_q, flen_d;
	logic        half_q, half_d;
	logic [2:0]  err_q, err_d;

	always_comb begin
		logic [31:0] vb_part;
		logic [31:0] id_full;
		logic [2:0]  k;
		logic [15:0] len;
		logic        fin;
		logic        pv;
		logic [2:0]  p_kind;
		logic [31:0] p_val;
		logic [15:0] p_len2;
		logic [2:0]  st;
		res_t        pres;
		res_t        eres;

		phase_d = phase_q;
		id_d    = id_q;
		acc_d   = acc_q;
		rem_d   = rem_q;
		vcnt_d  = vcnt_q;
		flen_d  = flen_q;
		half_d  = half_q;
		err_d   = err_q;
		fin     = 1'b0;
		pv      = 1'b0;
		p_kind  = KIND_BYTE;
		p_val   = '0;
		p_len2  = '0;
		id_full = '0;
		k       = KIND_UNKNOWN;
		len     = '0;
		st      = ST_OK;

		// 7-bit group of a variable byte integer placed at its position
		case (vcnt_q)
			2'd0:    vb_part = {25'd0, byte_in[6:0]};
			2'd1:    vb_part = {18'd0, byte_in[6:0], 7'd0};
			2'd2:    vb_part = {11'd0, byte_in[6:0], 14'd0};
			default: vb_part = {4'd0, byte_in[6:0], 21'd0};
		endcase

		if (err_q == ST_OK) begin
			case (phase_q)
				PH_ID: begin
					acc_d = acc_q | vb_part;
					if ((byte_in & VB_CONT) == 8'd0) begin
						vcnt_d  = '0;
						id_full = acc_d;
						acc_d   = '0;
						k = (id_full > 32'd127) ? KIND_UNKNOWN : kind_of(id_full[6:0]);
						if (k == KIND_UNKNOWN) begin
							err_d = ST_UNKNOWN;
						end else begin
							id_d   = id_full[6:0];
							half_d = 1'b0;
							case (k)
								KIND_BYTE: begin
									rem_d   = 16'd1;
									phase_d = PH_FIXED;
								end
								KIND_TWO: begin
									rem_d   = 16'd2;
									phase_d = PH_FIXED;
								end
								KIND_FOUR: begin
									rem_d   = 16'd4;
									phase_d = PH_FIXED;
								end
								KIND_VARINT: phase_d = PH_VARINT;
								default:     phase_d = PH_LEN_HI;
							endcase
						end
					end else if (vcnt_q == 2'd3) begin
						err_d = ST_MALFORMED;
					end else begin
						vcnt_d = vcnt_q + 2'd1;
					end
				end
				PH_FIXED: begin
					acc_d = {acc_q[23:0], byte_in};
					rem_d = rem_q - 16'd1;
					if (rem_d == 16'd0) begin
						pv      = 1'b1;
						p_kind  = kind_of(id_q);
						p_val   = acc_d;
						phase_d = PH_ID;
						acc_d   = '0;
					end
				end
				PH_VARINT: begin
					acc_d = acc_q | vb_part;
					if ((byte_in & VB_CONT) == 8'd0) begin
						vcnt_d  = '0;
						pv      = 1'b1;
						p_kind  = KIND_VARINT;
						p_val   = acc_d;
						phase_d = PH_ID;
						acc_d   = '0;
					end else if (vcnt_q == 2'd3) begin
						err_d = ST_MALFORMED;
					end else begin
						vcnt_d = vcnt_q + 2'd1;
					end
				end
				PH_LEN_HI: begin
					acc_d   = {24'd0, byte_in};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len = {acc_q[7:0], byte_in};
					k   = kind_of(id_q);
					if (k != KIND_BINARY && len > max_len) begin
						err_d = ST_TOO_LONG;
					end else begin
						acc_d = {16'd0, len};
						rem_d = len;
						if (len == 16'd0) begin
							fin = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					rem_d = rem_q - 16'd1;
					if (rem_d == 16'd0) begin
						fin = 1'b1;
					end
				end
				default: phase_d = PH_ID;
			endcase
		end

		// string / binary complete, or first half of a pair done
		if (fin) begin
			k = kind_of(id_q);
			if (k == KIND_PAIR && !half_q) begin
				flen_d  = acc_d[15:0];
				half_d  = 1'b1;
				phase_d = PH_LEN_HI;
			end else begin
				pv     = 1'b1;
				p_kind = k;
				if (k == KIND_PAIR) begin
					p_val  = {16'd0, flen_q};
					p_len2 = acc_d[15:0];
				end else begin
					p_val  = {16'd0, acc_d[15:0]};
				end
				phase_d = PH_ID;
				acc_d   = '0;
				rem_d   = '0;
				flen_d  = '0;
				half_d  = 1'b0;
			end
		end

		pres               = '0;
		pres.is_property   = 1'b1;
		pres.property_id   = id_d;
		pres.value_kind    = p_kind;
		pres.value         = p_val;
		pres.second_length = p_len2;
		pres.last_result   = !last_in;

		st = err_d;
		if (err_d == ST_OK && (phase_d != PH_ID || vcnt_d != 2'd0)) begin
			st = ST_TRUNC;
		end
		eres             = '0;
		eres.is_end      = 1'b1;
		eres.status      = st;
		eres.last_result = 1'b1;

		r0    = '0;
		r1    = '0;
		n_res = 2'd0;
		if (pv) begin
			r0    = pres;
			n_res = 2'd1;
			if (last_in) begin
				r1    = eres;
				n_res = 2'd2;
			end
		end else if (last_in) begin
			r0    = eres;
			n_res = 2'd1;
		end

		if (last_in) begin
			phase_d = PH_ID;
			id_d    = '0;
			acc_d   = '0;
			rem_d   = '0;
			vcnt_d  = '0;
			flen_d  = '0;
			half_d  = 1'b0;
			err_d   = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			id_q    <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			vcnt_q  <= '0;
			flen_q  <= '0;
			half_q  <= 1'b0;
			err_q   <= ST_OK;
		end else if (fire) begin
			phase_q <= phase_d;
			id_q    <= id_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			vcnt_q  <= vcnt_d;
			flen_q  <= flen_d;
			half_q  <= half_d;
			err_q   <= err_d;
		end
	end

endmodule

FILE: src/mqttp_out_fifo.sv
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on mqttp_pkg for the result type.
module mqttp_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  mqttp_pkg::res_t   push0,
	input  mqttp_pkg::res_t   push1,
	input  logic              pop,
	output mqttp_pkg::res_t   head,
	output logic              not_empty,
	output logic              room2
);
	import mqttp_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;
	logic [AW-1:0] wr_nx;

	assign wr_nx     = wr_q + AW'(1);
	assign head      = mem_q[rd_q];
	assign not_empty = cnt_q != '0;
	assign room2     = cnt_q <= (AW+1)'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_nx] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push_n);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + (AW+1)'(push_n) - (AW+1)'(pop);
		end
	end

endmodule

FILE: verif/mqttp_tb_pkg.sv
// Bench-side types and the property-area scoreboard for the MQTT 5 property parser bench.
// Depends on mqttp_pkg for the value kinds, status codes and the result beat layout.
package mqttp_tb_pkg;

	import mqttp_pkg::*;

	typedef enum logic [2:0] {
		AWAIT_ID,
		FIXED_BYTES,
		VARINT_VALUE,
		LEN_HIGH,
		LEN_LOW,
		SKIP_PAYLOAD
	} parse_phase_t;

	typedef enum logic [1:0] {
		VB_MORE,
		VB_DONE,
		VB_BAD
	} vbi_step_t;

	// Known property identifiers and their kinds, shared with the stimulus side
	localparam int unsigned NUM_KNOWN = 27;
	localparam logic [6:0] KNOWN_IDS [NUM_KNOWN] = '{
		7'h01, 7'h17, 7'h19, 7'h24, 7'h25, 7'h28, 7'h29, 7'h2A,
		7'h13, 7'h21, 7'h22, 7'h23,
		7'h02, 7'h11, 7'h18, 7'h27,
		7'h0B,
		7'h03, 7'h08, 7'h12, 7'h15, 7'h1A, 7'h1C, 7'h1F,
		7'h26,
		7'h09, 7'h16
	};
	localparam logic [2:0] KNOWN_KINDS [NUM_KNOWN] = '{
		KIND_BYTE, KIND_BYTE, KIND_BYTE, KIND_BYTE, KIND_BYTE, KIND_BYTE, KIND_BYTE, KIND_BYTE,
		KIND_TWO, KIND_TWO, KIND_TWO, KIND_TWO,
		KIND_FOUR, KIND_FOUR, KIND_FOUR, KIND_FOUR,
		KIND_VARINT,
		KIND_STRING, KIND_STRING, KIND_STRING, KIND_STRING, KIND_STRING, KIND_STRING,
		KIND_STRING,
		KIND_PAIR,
		KIND_BINARY, KIND_BINARY
	};

	class prop_area_model;
		logic [15:0]  limit;
		parse_phase_t ph;
		logic [6:0]   cur_id;
		logic [31:0]  acc;
		logic [15:0]  remaining;
		int unsigned  vbytes;
		logic [15:0]  first_len;
		bit           second_half;
		logic [2:0]   sticky;
		logic [2:0]   kind_tbl [128];
		res_t         expected_results [$];
		int unsigned  bytes_parsed;
		int unsigned  results_checked;
		int unsigned  properties_seen;
		int unsigned  ends_seen;
		int unsigned  mismatches;

		function new();
			foreach (kind_tbl[i])
				kind_tbl[i] = KIND_UNKNOWN;
			foreach (KNOWN_IDS[i])
				kind_tbl[KNOWN_IDS[i]] = KNOWN_KINDS[i];
			limit = 16'hFFFF;
			bytes_parsed = 0;
			results_checked = 0;
			properties_seen = 0;
			ends_seen = 0;
			mismatches = 0;
			clear_area();
		endfunction

		function logic [2:0] kind_for(int unsigned id);
			return (id > 127) ? KIND_UNKNOWN : kind_tbl[id];
		endfunction

		function void clear_area();
			ph = AWAIT_ID;
			cur_id = '0;
			acc = '0;
			remaining = '0;
			vbytes = 0;
			first_len = '0;
			second_half = 1'b0;
			sticky = ST_OK;
		endfunction

		function void set_limit(logic [15:0] v);
			limit = v;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function void queue_result(logic isp, logic [6:0] id, logic [2:0] kind,
				logic [31:0] val, logic [15:0] len2, logic ise, logic [2:0] st);
			res_t r;
			r = '{isp, id, kind, val, len2, ise, st, 1'b0};
			expected_results.push_back(r);
		endfunction

		function vbi_step_t add_vbi(logic [7:0] b);
			acc |= 32'(b & VB_DATA) << (7 * vbytes);
			if ((b & VB_CONT) == 8'h00) begin
				vbytes = 0;
				return VB_DONE;
			end
			if (vbytes == 3)
				return VB_BAD;
			vbytes++;
			return VB_MORE;
		endfunction

		// string/binary length done: pair first half loops back for the second length
		function void close_blob();
			logic [2:0] k;
			k = kind_tbl[cur_id];
			if (k == KIND_PAIR && !second_half) begin
				first_len = acc[15:0];
				second_half = 1'b1;
				ph = LEN_HIGH;
				return;
			end
			if (k == KIND_PAIR)
				queue_result(1'b1, cur_id, k, 32'(first_len), acc[15:0], 1'b0, ST_OK);
			else
				queue_result(1'b1, cur_id, k, 32'(acc[15:0]), 16'h0, 1'b0, ST_OK);
			ph = AWAIT_ID;
			acc = '0;
			remaining = '0;
			first_len = '0;
			second_half = 1'b0;
		endfunction

		// one accepted input beat: advance the parse and queue what it yields
		function void note_byte(logic [7:0] b, logic lst);
			int unsigned before_cnt;
			logic [31:0] id_val;
			logic [15:0] len;
			logic [2:0]  k;
			logic [2:0]  st;
			before_cnt = expected_results.size();
			bytes_parsed++;
			if (sticky == ST_OK) begin
				case (ph)
					AWAIT_ID: begin
						case (add_vbi(b))
							VB_BAD: sticky = ST_MALFORMED;
							VB_DONE: begin
								id_val = acc;
								acc = '0;
								k = kind_for(id_val);
								if (k == KIND_UNKNOWN) begin
									sticky = ST_UNKNOWN;
								end else begin
									cur_id = id_val[6:0];
									second_half = 1'b0;
									case (k)
										KIND_BYTE: begin
											remaining = 16'd1;
											ph = FIXED_BYTES;
										end
										KIND_TWO: begin
											remaining = 16'd2;
											ph = FIXED_BYTES;
										end
										KIND_FOUR: begin
											remaining = 16'd4;
											ph = FIXED_BYTES;
										end
										KIND_VARINT: ph = VARINT_VALUE;
										default: ph = LEN_HIGH;
									endcase
								end
							end
							default: ;
						endcase
					end
					FIXED_BYTES: begin
						acc = {acc[23:0], b};
						remaining--;
						if (remaining == 16'h0) begin
							queue_result(1'b1, cur_id, kind_tbl[cur_id], acc, 16'h0, 1'b0, ST_OK);
							ph = AWAIT_ID;
							acc = '0;
						end
					end
					VARINT_VALUE: begin
						case (add_vbi(b))
							VB_BAD: sticky = ST_MALFORMED;
							VB_DONE: begin
								queue_result(1'b1, cur_id, KIND_VARINT, acc, 16'h0, 1'b0, ST_OK);
								ph = AWAIT_ID;
								acc = '0;
							end
							default: ;
						endcase
					end
					LEN_HIGH: begin
						acc = 32'(b);
						ph = LEN_LOW;
					end
					LEN_LOW: begin
						len = {acc[7:0], b};
						if (kind_tbl[cur_id] != KIND_BINARY && len > limit) begin
							sticky = ST_TOO_LONG;
						end else begin
							acc = 32'(len);
							remaining = len;
							if (len == 16'h0)
								close_blob();
							else
								ph = SKIP_PAYLOAD;
						end
					end
					SKIP_PAYLOAD: begin
						remaining--;
						if (remaining == 16'h0)
							close_blob();
					end
					default: ph = AWAIT_ID;
				endcase
			end
			if (lst) begin
				st = sticky;
				if (st == ST_OK && (ph != AWAIT_ID || vbytes != 0))
					st = ST_TRUNC;
				queue_result(1'b0, 7'h0, 3'h0, 32'h0, 16'h0, 1'b1, st);
				clear_area();
			end
			if (expected_results.size() > before_cnt)
				expected_results[expected_results.size() - 1].last_result = 1'b1;
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				$error("result beat with nothing outstanding: 0x%0h", got);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			results_checked++;
			if (want.is_property)
				properties_seen++;
			if (want.is_end)
				ends_seen++;
			cmp_field("is_property", 32'(want.is_property), 32'(got.is_property));
			cmp_field("property_id", 32'(want.property_id), 32'(got.property_id));
			cmp_field("value_kind", 32'(want.value_kind), 32'(got.value_kind));
			cmp_field("value", want.value, got.value);
			cmp_field("second_length", 32'(want.second_length), 32'(got.second_length));
			cmp_field("is_end", 32'(want.is_end), 32'(got.is_end));
			cmp_field("status", 32'(want.status), 32'(got.status));
			cmp_field("last_result", 32'(want.last_result), 32'(got.last_result));
		endfunction
	endclass

endpackage

FILE: verif/testbench.sv
// Self-checking bench for mqtt5_property_stream_parser_top: directed areas, then random phases.
// Depends on mqttp_pkg, mqttp_tb_pkg and the parser RTL.
module testbench;

	import mqttp_pkg::*;
	import mqttp_tb_pkg::*;

	localparam int unsigned SETTLE_CYCLES   = 8;	// parse stage plus result queue, with margin
	localparam int unsigned WATCHDOG_LIMIT  = 3000;
	localparam int unsigned BYTES_PER_PHASE = 180;
	localparam int unsigned NUM_PHASES      = 6;

	// idling per mode: none, sender gaps, receiver stalls, both lightly
	localparam int unsigned IDLE_IN   [4] = '{0, 74, 0, 28};
	localparam int unsigned STALL_OUT [4] = '{0, 0, 74, 28};

	// directed areas; bit 8 flags the last byte of an area
	localparam int unsigned NUM_DIRECTED = 31;
	localparam logic [8:0] DIRECTED [NUM_DIRECTED] = '{
		// byte property completing on the last byte: property beat then end beat
		9'h001, 9'h1FF,
		// non-minimal id, four-byte all ones, widest varint, empty binary on last byte
		9'h082, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
		9'h00B, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,
		9'h009, 9'h000, 9'h100,
		// string pair with an empty second string, then a two-byte cut short
		9'h026, 9'h000, 9'h001, 9'h061, 9'h000, 9'h000, 9'h013, 9'h100,
		// id above 127 is unknown; the byte after it is ignored
		9'h080, 9'h001, 9'h155,
		// id varint still continuing on its fourth byte, which is also the last
		9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF
	};

	logic        clk               = 1'b0;
	logic        arst_n            = 1'b0;
	logic        in_valid          = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte         = 8'h00;
	logic        last_byte         = 1'b0;
	logic        out_valid;
	logic        out_stall         = 1'b0;
	logic        is_property;
	logic [6:0]  property_id;
	logic [2:0]  value_kind;
	logic [31:0] value;
	logic [15:0] second_length;
	logic        is_end;
	logic [2:0]  status;
	logic        last_result;
	logic        cfg_valid         = 1'b0;
	logic        cfg_ready;
	logic [15:0] max_string_length = 16'hFFFF;

	prop_area_model model;
	int unsigned    in_idle_pct   = 0;
	int unsigned    out_stall_pct = 0;
	int unsigned    cur_limit     = 16'hFFFF;	// what the stimulus believes the limit is
	int unsigned    quiet_cycles  = 0;
	int unsigned    areas_sent    = 0;
	logic [8:0]     area_q [$];

	mqtt5_property_stream_parser_top u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.data_byte         (data_byte),
		.last_byte         (last_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.is_property       (is_property),
		.property_id       (property_id),
		.value_kind        (value_kind),
		.value             (value),
		.second_length     (second_length),
		.is_end            (is_end),
		.status            (status),
		.last_result       (last_result),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.max_string_length (max_string_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	// all sampling on the rising edge: input beats feed the model, result beats are
	// checked against it, register writes update its limit; quiet cycles feed the watchdog
	always @(posedge clk) begin
		res_t got;
		bit   moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				model.note_byte(data_byte, last_byte);
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				got = '{is_property, property_id, value_kind, value, second_length,
					is_end, status, last_result};
				model.check_result(got);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				model.set_limit(max_string_length);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: %0d cycles without a beat, %0d results outstanding",
					quiet_cycles, model.pending());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// one input beat; called and returns at a falling edge, valid left high.
	// each cycle before the beat is idle with the sender's idle percentage
	task automatic send_byte(logic [7:0] b, logic lst);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// sender holds off until every outstanding result has drained, then settles
	task automatic hold_until_drained(int unsigned extra);
		in_valid <= 1'b0;
		do @(negedge clk); while (model.pending() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		cfg_valid         <= 1'b1;
		max_string_length <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_limit = v;
	endtask

	function automatic void put_byte(logic [7:0] b);
		area_q.push_back({1'b0, b});
	endfunction

	function automatic void put_noise(int unsigned n);
		repeat (n) put_byte(8'($urandom));
	endfunction

	// identifier as a varint, now and then padded out non-minimally to 2 to 4 bytes
	function automatic void put_id(logic [6:0] id);
		int unsigned pad;
		pad = ($urandom_range(99) < 15) ? $urandom_range(3, 1) : 0;
		if (pad == 0) begin
			put_byte({1'b0, id});
			return;
		end
		put_byte({1'b0, id} | VB_CONT);
		repeat (pad - 1) put_byte(VB_CONT);
		put_byte(8'h00);
	endfunction

	function automatic void put_vbi_value();
		int unsigned n;
		bit          all_ones;
		n = $urandom_range(4, 1);
		all_ones = ($urandom_range(9) == 0);
		repeat (n - 1) put_byte(all_ones ? 8'hFF : (8'($urandom) | VB_CONT));
		put_byte(all_ones ? VB_DATA : (8'($urandom) & VB_DATA));
	endfunction

	// length field plus payload; strings sometimes overshoot the limit on purpose
	function automatic void put_blob(logic [2:0] k);
		int unsigned pick;
		int unsigned len;
		int unsigned payload;
		pick = $urandom_range(99);
		if (k != KIND_BINARY && pick >= 80 && cur_limit < 16'hFFFF)
			len = $urandom_range(16'hFFFF, cur_limit + 1);
		else if (k == KIND_BINARY && pick >= 98)
			len = $urandom_range(300, 200);
		else if (pick >= 70)
			len = $urandom_range((cur_limit < 20) ? cur_limit : 20, 0);
		else
			len = $urandom_range(6, 0);
		put_byte(len[15:8]);
		put_byte(len[7:0]);
		// an over-long string stops the parse, so only a few trailing bytes are worth sending
		payload = (k != KIND_BINARY && len > cur_limit) ? ((len < 4) ? len : 4) : len;
		put_noise(payload);
	endfunction

	function automatic void put_property();
		int unsigned idx;
		logic [2:0]  k;
		idx = $urandom_range(NUM_KNOWN - 1);
		k = KNOWN_KINDS[idx];
		put_id(KNOWN_IDS[idx]);
		case (k)
			KIND_BYTE:   put_noise(1);
			KIND_TWO:    put_noise(2);
			KIND_FOUR:   put_noise(4);
			KIND_VARINT: put_vbi_value();
			KIND_PAIR: begin
				put_blob(k);
				put_blob(k);
			end
			default:     put_blob(k);
		endcase
	endfunction

	function automatic void put_unknown_id();
		logic [6:0] id;
		if ($urandom_range(1)) begin
			// two-byte varint worth 128 or more
			put_byte(8'($urandom) | VB_CONT);
			put_byte(8'($urandom_range(8'h7F, 8'h01)));
		end else begin
			do id = 7'($urandom); while (model.kind_for(id) != KIND_UNKNOWN);
			put_byte({1'b0, id});
		end
	endfunction

	// mostly well-formed areas with random content; the rest cut short, poisoned or noise
	function automatic void build_area();
		int unsigned pick;
		int unsigned cut;
		area_q.delete();
		pick = $urandom_range(99);
		repeat ($urandom_range(4, 1)) put_property();
		if (pick >= 68 && pick < 80) begin
			cut = $urandom_range(area_q.size(), 1);
			while (area_q.size() > cut)
				void'(area_q.pop_back());
		end else if (pick >= 80 && pick < 88) begin
			put_unknown_id();
			put_noise($urandom_range(3, 0));
		end else if (pick >= 88 && pick < 95) begin
			// varint still continuing on its fourth byte, in the id or in a value
			if ($urandom_range(1))
				put_id(7'h0B);
			repeat (4) put_byte(8'($urandom) | VB_CONT);
			put_noise($urandom_range(3, 0));
		end else if (pick >= 95) begin
			area_q.delete();
			put_noise($urandom_range(6, 1));
		end
		area_q[area_q.size() - 1][8] = 1'b1;
	endfunction

	initial begin
		logic [15:0] lim;
		int unsigned mode;
		int unsigned target;
		model = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed areas at the reset limit, no idling
		foreach (DIRECTED[i])
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

		for (int p = 0; p < NUM_PHASES; p++) begin
			// register writes only with the block drained and settled
			hold_until_drained(SETTLE_CYCLES);
			case (p)
				0:       lim = 16'hFFFF;
				1:       lim = 16'h0000;
				2:       lim = 16'd5;
				4:       lim = 16'd1;
				default: lim = 16'($urandom);
			endcase
			write_limit(lim);
			mode = p % 4;
			in_idle_pct   = IDLE_IN[mode];
			out_stall_pct = STALL_OUT[mode];
			target = model.bytes_parsed + BYTES_PER_PHASE;
			while (model.bytes_parsed < target) begin
				build_area();
				foreach (area_q[i])
					send_byte(area_q[i][7:0], area_q[i][8]);
				areas_sent++;
				// sender pauses now and then until every result is back
				if (areas_sent % 17 == 0)
					hold_until_drained(0);
			end
		end

		hold_until_drained(SETTLE_CYCLES);
		$display("coverage: %0d areas over %0d limit settings, %0d bytes sent",
			areas_sent + 5, NUM_PHASES, model.bytes_parsed);
		$display("results: %0d checked (%0d properties, %0d end beats), %0d mismatches",
			model.results_checked, model.properties_seen, model.ends_seen, model.mismatches);
		if (model.mismatches == 0 && model.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
